[design/permutation_cycle_mark_count_core_assert.svh]
// Assertion macros for the permutation cycle mark count core.
// Each macro expects signals named clk and rst in the including scope.
`ifndef PERMUTATION_CYCLE_MARK_COUNT_CORE_ASSERT_SVH
`define PERMUTATION_CYCLE_MARK_COUNT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCMC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcmc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PCMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcmc next-cycle check failed");

`endif

[design/pcmc_pkg.sv]
// Shared types and constants for the permutation cycle mark count core.
// No dependencies; used by every module in the design folder.
package pcmc_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = 10;
  localparam int COUNT_W     = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Walk bound in steps, and the width of the step counter.
  localparam int DEPTH  = 1024;
  localparam int STEP_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  // Operation codes of an input word.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Input word.
  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] elem_index;
    logic [IDX_W-1:0] successor;
    logic             is_marked;
  } pcmc_in_t;

  // Result word.
  typedef struct packed {
    logic [COUNT_W-1:0] marked_count;
    logic               not_permutation;
  } pcmc_out_t;

  // One table entry: mark bit and successor.
  typedef struct packed {
    logic             marked;
    logic [IDX_W-1:0] successor;
  } pcmc_entry_t;

  // Table access from the sequencer.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    pcmc_entry_t      wr_entry;
    logic [IDX_W-1:0] rd_addr;
  } pcmc_tbl_req_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    pcmc_out_t word;
  } pcmc_res_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } pcmc_state_t;

endpackage

[design/permutation_cycle_mark_count_core.sv]
// Top level of the permutation cycle mark count core.
// Depends on pcmc_pkg, pcmc_table, pcmc_walk and the assertion header.
//
// Usage:
//   The input channel (in_valid, in_stall, in_word) takes one word at a time.
//   A load word (op = load) writes one element's successor and mark into the
//   1024-entry table, gives no result and does not raise in_stall. A query
//   word starts a walk from elem_index; the walk reads the table once per
//   cycle and counts marked elements until the start element comes back or
//   DEPTH steps pass. One result word (marked_count, not_permutation) leaves
//   on the output channel (out_valid, out_stall, out_word) per query. The
//   single table read port sets one walk step per cycle. in_stall stays high
//   for the whole walk and low again once the result moves to the output
//   register. The output register holds a result while out_stall is high; a
//   following query can still walk, and waits in its final state until the
//   register frees up. Reset clears control state only; table entries stay
//   undefined until loaded, and no clearing pass runs.
`include "permutation_cycle_mark_count_core_assert.svh"

module permutation_cycle_mark_count_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcmc_pkg::pcmc_in_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pcmc_pkg::pcmc_out_t out_word
);

  pcmc_pkg::pcmc_tbl_req_t tbl_req;
  pcmc_pkg::pcmc_entry_t   rd_entry;
  pcmc_pkg::pcmc_res_t     res;
  logic                    res_take;
  logic                    in_take;

  // Table storage.
  pcmc_table u_table (
    .clk      (clk),
    .req      (tbl_req),
    .rd_entry (rd_entry)
  );

  // Walk sequencer.
  pcmc_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_stall (in_stall),
    .tbl_req  (tbl_req),
    .rd_entry (rd_entry),
    .res      (res),
    .res_take (res_take)
  );

  // Output register: refilled when empty or when its word is taken.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_word <= res.word;
    end
  end

  // Input handshake, shared by the checks.
  assign in_take = in_valid && !in_stall;

  // Checks.
  `PCMC_ASSERT_SAME(a_idle_no_result, !in_stall, !res.valid)
  `PCMC_ASSERT_NEXT(a_query_busy, in_take && (in_word.op == pcmc_pkg::OP_QUERY), in_stall)
  `PCMC_ASSERT_NEXT(a_load_one_cycle, in_take && (in_word.op == pcmc_pkg::OP_LOAD), !in_stall)
  `PCMC_ASSERT_NEXT(a_result_lands, res.valid && res_take, out_valid && !res.valid)

endmodule

[design/pcmc_table.sv]
// Permutation table: one write port and one registered read port.
// Depends on pcmc_pkg for the entry and request types.
module pcmc_table (
  input  logic                   clk,
  input  pcmc_pkg::pcmc_tbl_req_t req,
  output pcmc_pkg::pcmc_entry_t   rd_entry
);

  pcmc_pkg::pcmc_entry_t mem [pcmc_pkg::TABLE_DEPTH];

  // Write port, used by loads.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_entry;
    end
  end

  // Read port, data in the cycle after the address.
  always_ff @(posedge clk) begin
    rd_entry <= mem[req.rd_addr];
  end

endmodule

[design/pcmc_walk.sv]
// Walk sequencer: takes input words, writes loads into the table and
// walks a queried cycle one table read per cycle. Depends on pcmc_pkg.
module pcmc_walk (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  pcmc_pkg::pcmc_in_t      in_word,
  output logic                    in_stall,
  output pcmc_pkg::pcmc_tbl_req_t tbl_req,
  input  pcmc_pkg::pcmc_entry_t   rd_entry,
  output pcmc_pkg::pcmc_res_t     res,
  input  logic                    res_take
);

  pcmc_pkg::pcmc_state_t state, state_next;

  logic [pcmc_pkg::IDX_W-1:0]   start;
  logic [pcmc_pkg::COUNT_W-1:0] count;
  logic [pcmc_pkg::STEP_W-1:0]  step;
  logic                         fail;

  logic                         accept;
  logic                         is_query;
  logic [pcmc_pkg::COUNT_W-1:0] count_step;
  logic                         hit;
  logic                         last;

  // Step datapath: saturating count, return test and bound test.
  assign accept     = (state == pcmc_pkg::ST_IDLE) && in_valid;
  assign is_query   = (in_word.op == pcmc_pkg::OP_QUERY);
  assign count_step = (rd_entry.marked && (count != pcmc_pkg::COUNT_MAX))
                      ? count + pcmc_pkg::COUNT_W'(1) : count;
  assign hit        = (rd_entry.successor == start);
  assign last       = (step == pcmc_pkg::STEP_W'(pcmc_pkg::DEPTH - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pcmc_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          state_next = pcmc_pkg::ST_WALK;
        end
      end
      pcmc_pkg::ST_WALK: begin
        if (hit || last) begin
          state_next = pcmc_pkg::ST_FINISH;
        end
      end
      pcmc_pkg::ST_FINISH: begin
        if (res_take) begin
          state_next = pcmc_pkg::ST_IDLE;
        end
      end
      default: state_next = pcmc_pkg::ST_IDLE;
    endcase
  end

  // Outputs: handshake, table access and result.
  always_comb begin
    in_stall          = 1'b1;
    tbl_req.wr_en     = 1'b0;
    tbl_req.wr_addr   = in_word.elem_index;
    tbl_req.wr_entry  = '{marked: in_word.is_marked, successor: in_word.successor};
    tbl_req.rd_addr   = in_word.elem_index;
    res.valid         = 1'b0;
    res.word          = '{marked_count: count, not_permutation: fail};
    case (state)
      pcmc_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        tbl_req.wr_en = accept && !is_query;
      end
      pcmc_pkg::ST_WALK: begin
        tbl_req.rd_addr = rd_entry.successor;
      end
      pcmc_pkg::ST_FINISH: begin
        res.valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    case (state)
      pcmc_pkg::ST_IDLE: begin
        start <= in_word.elem_index;
        count <= '0;
        step  <= '0;
        fail  <= 1'b0;
      end
      pcmc_pkg::ST_WALK: begin
        count <= count_step;
        step  <= step + pcmc_pkg::STEP_W'(1);
        fail  <= !hit;
      end
      default: begin
        count <= count;
      end
    endcase
  end

endmodule
